[hw/rtl/tgr_pkg.sv]
// Shared types, widths and constants of the touch gesture recognizer.
package tgr_pkg;

   localparam int RAW_BITS       = 12;
   localparam int TIME_BITS      = 32;
   localparam int CAL_BITS       = 12;
   localparam int SCR_BITS       = 12;
   localparam int THR_BITS       = 12;
   localparam int TOL_BITS       = 12;
   localparam int MS_BITS        = 16;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;

   localparam int VAL_BITS   = (RAW_BITS > CAL_BITS) ? RAW_BITS : CAL_BITS;
   localparam int DIFF_BITS  = VAL_BITS + 1;
   localparam int NUM_BITS   = VAL_BITS + SCR_BITS;
   localparam int Q_BITS     = SCR_BITS;
   localparam int SQ_BITS    = 2 * SCR_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int TOLSQ_BITS = 2 * TOL_BITS;
   localparam int STEP_BITS  = $clog2(Q_BITS);
   localparam int AXES       = 2;
   localparam int AXIS_X     = 0;
   localparam int AXIS_Y     = 1;

   localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(Q_BITS - 1);
   localparam int TAP_MIN_MS = 30;

   typedef enum logic [1:0] {
      KIND_TAP  = 2'd0,
      KIND_LONG = 2'd1,
      KIND_DRAG = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CAL_X     = 3'd0,
      REG_CAL_Y     = 3'd1,
      REG_SCREEN    = 3'd2,
      REG_PRESS_THR = 3'd3,
      REG_MODE      = 3'd4,
      REG_TOL       = 3'd5,
      REG_LONG      = 3'd6,
      REG_DEBOUNCE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                 touched;
      logic [RAW_BITS-1:0]  raw_x;
      logic [RAW_BITS-1:0]  raw_y;
      logic [RAW_BITS-1:0]  pressure;
      logic [TIME_BITS-1:0] now_ms;
   } req_type;

   typedef struct packed {
      kind_type            event_kind;
      logic [SCR_BITS-1:0] point_x;
      logic [SCR_BITS-1:0] point_y;
      logic [SCR_BITS-1:0] origin_x;
      logic [SCR_BITS-1:0] origin_y;
   } rsp_type;

   typedef struct packed {
      logic [CAL_BITS-1:0] cal_x_lo;
      logic [CAL_BITS-1:0] cal_x_hi;
      logic [CAL_BITS-1:0] cal_y_lo;
      logic [CAL_BITS-1:0] cal_y_hi;
      logic [SCR_BITS-1:0] scr_w;
      logic [SCR_BITS-1:0] scr_h;
      logic [THR_BITS-1:0] press_thr;
      logic                swap;
      logic                inv_x;
      logic                inv_y;
      logic                enable;
      logic [TOL_BITS-1:0] tol;
      logic [MS_BITS-1:0]  long_ms;
      logic [MS_BITS-1:0]  debounce_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cal_x_lo:    12'h000,
      cal_x_hi:    12'hfff,
      cal_y_lo:    12'h000,
      cal_y_hi:    12'hfff,
      scr_w:       12'd320,
      scr_h:       12'd240,
      press_thr:   12'd400,
      swap:        1'b0,
      inv_x:       1'b0,
      inv_y:       1'b0,
      enable:      1'b1,
      tol:         12'd10,
      long_ms:     16'd600,
      debounce_ms: 16'd50
   };

   typedef struct packed {
      logic capture;
      logic mul;
      logic div_load;
      logic div_step;
      logic scale_write;
      logic square;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic enabled;
      logic touched;
      logic pressure_ok;
      logic pressed;
      logic debounce_ok;
      logic emit;
      logic out_busy;
   } status_type;

endpackage

[hw/rtl/tgr_div_lane.sv]
// Restoring divider lane, one quotient bit per step.
module tgr_div_lane (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [tgr_pkg::CAL_BITS-1:0]  rem_init,
   input  logic [tgr_pkg::Q_BITS-1:0]    quo_init,
   input  logic [tgr_pkg::CAL_BITS-1:0]  divisor,
   output logic [tgr_pkg::Q_BITS-1:0]    quotient
);
   import tgr_pkg::*;

   logic [CAL_BITS-1:0] rem_ff, rem_in;
   logic [Q_BITS-1:0]   quo_ff, quo_in;
   logic [CAL_BITS:0]   trial;
   logic [CAL_BITS:0]   trial_sub;
   logic                fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[Q_BITS-1]};
      fits      = trial >= {1'b0, divisor};
      trial_sub = trial - {1'b0, divisor};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (load) begin
         rem_in = rem_init;
         quo_in = quo_init;
      end else if (step) begin
         rem_in = fits ? trial_sub[CAL_BITS-1:0] : trial[CAL_BITS-1:0];
         quo_in = {quo_ff[Q_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

[hw/rtl/tgr_datapath.sv]
// Datapath: sample capture, axis scaling, distance test, gesture state, result beat.
module tgr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tgr_pkg::cfg_type     cfg,
   input  tgr_pkg::req_type     req_data,
   input  tgr_pkg::cmd_type     cmd,
   output tgr_pkg::status_type  status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tgr_pkg::rsp_type     rsp_data
);
   import tgr_pkg::*;

   req_type               sample_ff, sample_in;
   logic                  is_pressed_ff, is_pressed_in;
   logic                  long_fired_ff, long_fired_in;
   logic [TIME_BITS-1:0]  press_time_ff, press_time_in;
   logic [TIME_BITS-1:0]  release_time_ff, release_time_in;
   logic [SCR_BITS-1:0]   begin_x_ff, begin_x_in, begin_y_ff, begin_y_in;
   logic [SCR_BITS-1:0]   recent_x_ff, recent_x_in, recent_y_ff, recent_y_in;
   logic [AXES-1:0][NUM_BITS-1:0] num_ff, num_in;
   logic [SQ_BITS-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [TOLSQ_BITS-1:0] tol2_ff, tol2_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [AXES-1:0][VAL_BITS-1:0]  ax_val;
   logic [AXES-1:0][CAL_BITS-1:0]  ax_lo;
   logic [AXES-1:0][CAL_BITS-1:0]  ax_hi;
   logic [AXES-1:0][CAL_BITS-1:0]  ax_den;
   logic [AXES-1:0][SCR_BITS-1:0]  ax_size;
   logic [AXES-1:0][SCR_BITS-1:0]  ax_size_m1;
   logic [AXES-1:0][SCR_BITS-1:0]  ax_pos;
   logic [AXES-1:0][SCR_BITS-1:0]  ax_point;
   logic [AXES-1:0][VAL_BITS-1:0]  ax_diff_mag;
   logic [AXES-1:0][DIFF_BITS-1:0] ax_diff;
   logic [AXES-1:0][DIFF_BITS-1:0] ax_span;
   logic [AXES-1:0][Q_BITS-1:0]    ax_quo;
   logic [AXES-1:0]                ax_inv, ax_neg, ax_eq, ax_sat;

   logic [RAW_BITS-1:0]  tx, ty;
   logic [DIFF_BITS-1:0] dx, dy;
   logic [SCR_BITS-1:0]  dx_mag, dy_mag;
   logic [SUM_BITS-1:0]  m2;
   logic [TIME_BITS-1:0] held, since_release;
   logic                 in_tol, tap_cond, long_cond, emit, release_beat;
   kind_type             kind;

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      tgr_div_lane u_div (
         .clock    (clock),
         .load     (cmd.div_load),
         .step     (cmd.div_step),
         .rem_init (num_ff[a][NUM_BITS-1:Q_BITS]),
         .quo_init (num_ff[a][Q_BITS-1:0]),
         .divisor  (ax_den[a]),
         .quotient (ax_quo[a])
      );
   end

   always_comb begin
      tx = cfg.swap ? sample_ff.raw_y : sample_ff.raw_x;
      ty = cfg.swap ? sample_ff.raw_x : sample_ff.raw_y;
      ax_val[AXIS_X]  = VAL_BITS'(tx);
      ax_val[AXIS_Y]  = VAL_BITS'(ty);
      ax_lo[AXIS_X]   = cfg.cal_x_lo;
      ax_lo[AXIS_Y]   = cfg.cal_y_lo;
      ax_hi[AXIS_X]   = cfg.cal_x_hi;
      ax_hi[AXIS_Y]   = cfg.cal_y_hi;
      ax_size[AXIS_X] = cfg.scr_w;
      ax_size[AXIS_Y] = cfg.scr_h;
      ax_inv[AXIS_X]  = cfg.inv_x;
      ax_inv[AXIS_Y]  = cfg.inv_y;
      for (int a = 0; a < AXES; a++) begin
         ax_diff[a]     = DIFF_BITS'(ax_val[a]) - DIFF_BITS'(ax_lo[a]);
         ax_span[a]     = DIFF_BITS'(ax_hi[a]) - DIFF_BITS'(ax_lo[a]);
         ax_diff_mag[a] = VAL_BITS'(ax_diff[a][DIFF_BITS-1] ? -ax_diff[a] : ax_diff[a]);
         ax_den[a]      = CAL_BITS'(ax_span[a][DIFF_BITS-1] ? -ax_span[a] : ax_span[a]);
         ax_neg[a]      = ax_diff[a][DIFF_BITS-1] ^ ax_span[a][DIFF_BITS-1];
         ax_eq[a]       = (ax_hi[a] == ax_lo[a]);
         ax_size_m1[a]  = ax_size[a] - 1'b1;
         ax_sat[a]      = (num_ff[a][NUM_BITS-1:Q_BITS] >= ax_den[a]);
         num_in[a]      = cmd.mul ? NUM_BITS'(ax_diff_mag[a]) * NUM_BITS'(ax_size_m1[a])
                                  : num_ff[a];
         if (ax_eq[a] || ax_neg[a]) begin
            ax_pos[a] = '0;
         end else if (ax_sat[a] || (ax_quo[a] > ax_size_m1[a])) begin
            ax_pos[a] = ax_size_m1[a];
         end else begin
            ax_pos[a] = ax_quo[a];
         end
         ax_point[a] = ax_inv[a] ? (ax_size_m1[a] - ax_pos[a]) : ax_pos[a];
      end
   end

   always_comb begin
      dx      = DIFF_BITS'(recent_x_ff) - DIFF_BITS'(begin_x_ff);
      dy      = DIFF_BITS'(recent_y_ff) - DIFF_BITS'(begin_y_ff);
      dx_mag  = SCR_BITS'(dx[DIFF_BITS-1] ? -dx : dx);
      dy_mag  = SCR_BITS'(dy[DIFF_BITS-1] ? -dy : dy);
      sqx_in  = cmd.square ? SQ_BITS'(dx_mag) * SQ_BITS'(dx_mag) : sqx_ff;
      sqy_in  = cmd.square ? SQ_BITS'(dy_mag) * SQ_BITS'(dy_mag) : sqy_ff;
      tol2_in = cmd.square ? TOLSQ_BITS'(cfg.tol) * TOLSQ_BITS'(cfg.tol) : tol2_ff;

      m2            = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
      in_tol        = (m2 <= SUM_BITS'(tol2_ff));
      held          = sample_ff.now_ms - press_time_ff;
      since_release = sample_ff.now_ms - release_time_ff;
      release_beat  = !sample_ff.touched;
      tap_cond      = !long_fired_ff && (held >= TIME_BITS'(TAP_MIN_MS)) && in_tol;
      long_cond     = !long_fired_ff && in_tol && (held >= TIME_BITS'(cfg.long_ms));
      emit          = release_beat ? tap_cond : (long_cond || !in_tol);
      if (release_beat) begin
         kind = KIND_TAP;
      end else if (long_cond) begin
         kind = KIND_LONG;
      end else begin
         kind = KIND_DRAG;
      end

      sample_in       = cmd.capture ? req_data : sample_ff;
      is_pressed_in   = is_pressed_ff;
      long_fired_in   = long_fired_ff;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      begin_x_in      = begin_x_ff;
      begin_y_in      = begin_y_ff;
      recent_x_in     = recent_x_ff;
      recent_y_in     = recent_y_ff;
      if (cmd.scale_write) begin
         recent_x_in = ax_point[AXIS_X];
         recent_y_in = ax_point[AXIS_Y];
         if (!is_pressed_ff) begin
            is_pressed_in = 1'b1;
            long_fired_in = 1'b0;
            press_time_in = sample_ff.now_ms;
            begin_x_in    = ax_point[AXIS_X];
            begin_y_in    = ax_point[AXIS_Y];
         end
      end
      if (cmd.commit) begin
         if (release_beat) begin
            is_pressed_in   = 1'b0;
            long_fired_in   = 1'b0;
            release_time_in = sample_ff.now_ms;
         end else if (long_cond) begin
            long_fired_in = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.commit && emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.event_kind = kind;
         rsp_data_in.point_x  = recent_x_ff;
         rsp_data_in.point_y  = recent_y_ff;
         rsp_data_in.origin_x = begin_x_ff;
         rsp_data_in.origin_y = begin_y_ff;
      end

      status.enabled     = cfg.enable && (cfg.scr_w != '0) && (cfg.scr_h != '0);
      status.touched     = sample_ff.touched;
      status.pressure_ok = (sample_ff.pressure >= cfg.press_thr);
      status.pressed     = is_pressed_ff;
      status.debounce_ok = (since_release >= TIME_BITS'(cfg.debounce_ms));
      status.emit        = emit;
      status.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff       <= '0;
         is_pressed_ff   <= 1'b0;
         long_fired_ff   <= 1'b0;
         press_time_ff   <= '0;
         release_time_ff <= '0;
         begin_x_ff      <= '0;
         begin_y_ff      <= '0;
         recent_x_ff     <= '0;
         recent_y_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sample_ff       <= sample_in;
         is_pressed_ff   <= is_pressed_in;
         long_fired_ff   <= long_fired_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         begin_x_ff      <= begin_x_in;
         begin_y_ff      <= begin_y_in;
         recent_x_ff     <= recent_x_in;
         recent_y_ff     <= recent_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      tol2_ff     <= tol2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result beat dropped or changed while waiting");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && emit) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result committed over a pending beat");

   a_point_on_screen: assert property (@(posedge clock) disable iff (reset)
      cmd.scale_write |-> ((ax_point[AXIS_X] < cfg.scr_w) && (ax_point[AXIS_Y] < cfg.scr_h)))
      else $error("scaled point outside the screen");
`endif

endmodule

[hw/rtl/tgr_ctrl.sv]
// Controller: sequences capture, scaling, division, distance test and commit.
module tgr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tgr_pkg::status_type status,
   output tgr_pkg::cmd_type    cmd
);
   import tgr_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOAD  = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_SAT   = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_SCALE = 8'b0010_0000,
      ST_SQR   = 8'b0100_0000,
      ST_CMP   = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!status.enabled) begin
               state_in = ST_IDLE;
            end else if (!status.touched) begin
               state_in = status.pressed ? ST_SQR : ST_IDLE;
            end else if (!status.pressure_ok || (!status.pressed && !status.debounce_ok)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_SCALE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale_write = 1'b1;
            state_in        = status.pressed ? ST_SQR : ST_IDLE;
         end
         ST_SQR: begin
            cmd.square = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            if (!(status.emit && status.out_busy)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

`ifndef NO_ASSERTIONS
   a_div_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff != DIV_LAST)
      |=> (state_ff == ST_DIV && step_ff == $past(step_ff) + 1'b1))
      else $error("divider run cut short");

   a_scale_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> $past(state_ff == ST_DIV && step_ff == DIV_LAST))
      else $error("scale entered without a full divider run");

   a_hold_on_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && status.emit && status.out_busy) |=> (state_ff == ST_CMP))
      else $error("result dropped while output beat pending");
`endif

endmodule

[hw/rtl/touch_gesture_recognizer_unit.sv]
// Top level of the touch gesture recognizer: register file, controller and datapath.
//
// One touch poll is taken per req_ beat; each poll yields zero or one rsp_ beat
// (tap, long press or drag); the next poll is accepted once the last is done. A
// touched poll is multiplied, then two 12-step restoring divider lanes scale x and
// y in parallel; a held press goes on to square and compare, as a release does. An
// ignored poll (block disabled, low pressure, debounce pending or release without
// press) returns to idle. A finished result waits in an output register, so the
// next poll is accepted while it is pending; a poll that must emit before that beat
// is taken holds until it is. The user writes registers through csr_we, csr_index
// and csr_wdata only while idle; the block itself does not enforce this.
module touch_gesture_recognizer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tgr_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tgr_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [tgr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tgr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tgr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CAL_X: begin
               cfg_in.cal_x_lo = csr_wdata[CAL_BITS-1:0];
               cfg_in.cal_x_hi = csr_wdata[2*CAL_BITS-1:CAL_BITS];
            end
            REG_CAL_Y: begin
               cfg_in.cal_y_lo = csr_wdata[CAL_BITS-1:0];
               cfg_in.cal_y_hi = csr_wdata[2*CAL_BITS-1:CAL_BITS];
            end
            REG_SCREEN: begin
               cfg_in.scr_w = csr_wdata[SCR_BITS-1:0];
               cfg_in.scr_h = csr_wdata[2*SCR_BITS-1:SCR_BITS];
            end
            REG_PRESS_THR: begin
               cfg_in.press_thr = csr_wdata[THR_BITS-1:0];
            end
            REG_MODE: begin
               cfg_in.swap   = csr_wdata[0];
               cfg_in.inv_x  = csr_wdata[1];
               cfg_in.inv_y  = csr_wdata[2];
               cfg_in.enable = csr_wdata[3];
            end
            REG_TOL: begin
               cfg_in.tol = csr_wdata[TOL_BITS-1:0];
            end
            REG_LONG: begin
               cfg_in.long_ms = csr_wdata[MS_BITS-1:0];
            end
            REG_DEBOUNCE: begin
               cfg_in.debounce_ms = csr_wdata[MS_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tgr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
